/* design/touch_report_tracker_defines.svh */
// Assertion macros shared by the touch report tracker modules.
`ifndef TOUCH_REPORT_TRACKER_DEFINES_SVH
`define TOUCH_REPORT_TRACKER_DEFINES_SVH

// Same-cycle check, muted while reset is held.
`define TRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("touch report tracker check failed");

// Next-cycle check, muted while reset is held.
`define TRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch report tracker check failed");

`endif

/* design/trt_pkg.sv */
// Types, constants and helpers shared by the touch report tracker.
package trt_pkg;

  localparam int NPTS_MAX = 5;
  localparam int COORD_W  = 16;
  localparam int MASK_W   = 8;
  localparam int IDX_W    = 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [MASK_W-1:0]  mask_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MAX_X = 1'b0,
    REG_MAX_Y = 1'b1
  } cfg_reg_t;

  localparam coord_t MAX_X_RST   = 16'd800;
  localparam coord_t MAX_Y_RST   = 16'd480;
  localparam coord_t CLEARED     = 16'hFFFF;
  localparam mask_t  PRESS_BIT   = 8'h80;
  localparam mask_t  CAUGHT_BIT  = 8'h40;
  localparam mask_t  NOTOUCH_SEL = 8'h8F;
  localparam mask_t  NOTOUCH_VAL = 8'h80;
  localparam mask_t  KEEP_NOPRS  = 8'h7F;
  localparam mask_t  KEEP_HIGH   = 8'hE0;
  localparam logic [7:0] POLL_LIMIT  = 8'd240;
  localparam logic [7:0] POLL_RELOAD = 8'd10;
  localparam logic [7:0] POLL_EARLY  = 8'd10;
  localparam logic [3:0] MOD_LAST    = 4'd9;

  // Result flags that travel with one tick's snapshot
  typedef struct packed {
    mask_t mask;
    logic  new_touch;
    logic  clear_req;
  } trt_flags_t;

  // Valid-slot bits for a touch count of one to five
  function automatic logic [4:0] low_mask(input logic [3:0] cnt);
    logic [4:0] m;
    unique case (cnt)
      4'd1:    m = 5'b00001;
      4'd2:    m = 5'b00011;
      4'd3:    m = 5'b00111;
      4'd4:    m = 5'b01111;
      4'd5:    m = 5'b11111;
      default: m = 5'b00000;
    endcase
    return m;
  endfunction

endpackage

/* design/trt_core.sv */
// Tracker state and the per-tick update of poll counter, touch mask and slots.
`include "touch_report_tracker_defines.svh"

module trt_core #(
  parameter int NUM_POINTS = 5
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we_i,
  input  logic                                     cfg_index_i,
  input  trt_pkg::coord_t                          cfg_wdata_i,
  input  logic                                     fire_i,
  input  logic [7:0]                               status_i,
  input  trt_pkg::coord_t [trt_pkg::NPTS_MAX-1:0]  pt_x_i,
  input  trt_pkg::coord_t [trt_pkg::NPTS_MAX-1:0]  pt_y_i,
  output trt_pkg::coord_t [NUM_POINTS-1:0]         trk_x_o,
  output trt_pkg::coord_t [NUM_POINTS-1:0]         trk_y_o,
  output trt_pkg::trt_flags_t                      flags_o
);
  import trt_pkg::*;

  logic [7:0] poll_r, poll_nxt;
  logic [3:0] mod_r, mod_nxt;
  mask_t      flags_r, flags_nxt;
  coord_t [NUM_POINTS-1:0] trk_x_r, trk_y_r, trk_x_nxt, trk_y_nxt;
  coord_t     max_x_r, max_y_r;

  logic [7:0] pc1, poll_pre;
  logic [3:0] pc1_mod, cnt;
  logic       sampled, cnt_ok, clr, load, bad, rollback, take, notouch;
  mask_t      flags_pre;

  // Poll counter step; mod_r tracks poll_r modulo ten
  always_comb begin
    pc1     = poll_r + 8'd1;
    pc1_mod = (poll_r == 8'hFF || mod_r == MOD_LAST) ? 4'd0 : mod_r + 4'd1;
    sampled = (pc1_mod == 4'd0) || (pc1 < POLL_EARLY);
  end

  // Report decode
  always_comb begin
    cnt      = status_i[3:0];
    cnt_ok   = cnt <= 4'(NUM_POINTS);
    clr      = sampled && status_i[7] && cnt_ok;
    load     = sampled && (cnt != 4'd0) && cnt_ok;
    bad      = (pt_x_i[0] > max_x_r) || (pt_y_i[0] > max_y_r);
    rollback = load && bad && (cnt == 4'd1);
    take     = load && !rollback;
    notouch  = rollback || (sampled && ((status_i & NOTOUCH_SEL) == NOTOUCH_VAL));
    flags_pre = take ? (PRESS_BIT | CAUGHT_BIT | {3'b000, low_mask(cnt)}) : flags_r;
  end

  // Slot loading, backup copy of slot 0 and release handling
  always_comb begin
    trk_x_nxt = trk_x_r;
    trk_y_nxt = trk_y_r;
    for (int i = 1; i < NUM_POINTS; i++) begin
      if (load && i == NUM_POINTS - 1) begin
        trk_x_nxt[i] = trk_x_r[0];
        trk_y_nxt[i] = trk_y_r[0];
      end
      if (load && 4'(i) < cnt) begin
        trk_x_nxt[i] = pt_x_i[i];
        trk_y_nxt[i] = pt_y_i[i];
      end
    end
    // slot 0: out-of-range point falls back to point 1
    if (take) begin
      trk_x_nxt[0] = bad ? pt_x_i[1] : pt_x_i[0];
      trk_y_nxt[0] = bad ? pt_y_i[1] : pt_y_i[0];
    end
    flags_nxt = flags_pre;
    if (notouch) begin
      if (flags_pre[7]) begin
        flags_nxt = flags_pre & KEEP_NOPRS;
      end else begin
        flags_nxt    = flags_pre & KEEP_HIGH;
        trk_x_nxt[0] = CLEARED;
        trk_y_nxt[0] = CLEARED;
      end
    end
    poll_pre = take ? 8'd0 : pc1;
    poll_nxt = (poll_pre > POLL_LIMIT) ? POLL_RELOAD : poll_pre;
    mod_nxt  = (take || poll_pre > POLL_LIMIT) ? 4'd0 : pc1_mod;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r  <= '0;
      mod_r   <= '0;
      flags_r <= '0;
      trk_x_r <= '0;
      trk_y_r <= '0;
    end else if (fire_i) begin
      poll_r  <= poll_nxt;
      mod_r   <= mod_nxt;
      flags_r <= flags_nxt;
      trk_x_r <= trk_x_nxt;
      trk_y_r <= trk_y_nxt;
    end
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= MAX_X_RST;
      max_y_r <= MAX_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_X: max_x_r <= cfg_wdata_i;
        REG_MAX_Y: max_y_r <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  assign trk_x_o = trk_x_nxt;
  assign trk_y_o = trk_y_nxt;
  assign flags_o = '{mask: flags_nxt, new_touch: load, clear_req: clr};

  `TRT_ASSERT_NOW(a_poll_range, 1'b1, poll_r <= POLL_LIMIT)
  `TRT_ASSERT_NOW(a_mod_range, 1'b1, mod_r <= MOD_LAST)
  `TRT_ASSERT_NEXT(a_take_rearms, fire_i && take, (poll_r == 8'd0) && flags_r[6])

endmodule

/* design/trt_emit.sv */
// Result buffer: holds one tick's slots and sends them one per cycle while out_ready is high.
`include "touch_report_tracker_defines.svh"

module trt_emit #(
  parameter int NUM_POINTS = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load_i,
  input  trt_pkg::coord_t [NUM_POINTS-1:0]    x_i,
  input  trt_pkg::coord_t [NUM_POINTS-1:0]    y_i,
  input  trt_pkg::trt_flags_t                 flags_i,
  output logic                                can_load_o,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [trt_pkg::IDX_W-1:0]           out_slot_index,
  output trt_pkg::coord_t                     out_slot_x,
  output trt_pkg::coord_t                     out_slot_y,
  output trt_pkg::mask_t                      out_touch_mask,
  output logic                                out_new_touch,
  output logic                                out_clear_request,
  output logic                                out_last_slot
);
  import trt_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

  logic                    busy_r;
  logic [IDX_W-1:0]        idx_r;
  coord_t [NUM_POINTS-1:0] sx_r, sy_r;
  trt_flags_t              flg_r;
  logic                    last, pop;

  assign last       = idx_r == LAST_IDX;
  assign pop        = busy_r && out_ready;
  assign can_load_o = !busy_r || (out_ready && last);

  // Control: busy flag and slot counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load_i) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (pop) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Slot shift line: the head is always the slot on the port
  always_ff @(posedge clk) begin
    if (load_i) begin
      sx_r  <= x_i;
      sy_r  <= y_i;
      flg_r <= flags_i;
    end else if (pop) begin
      for (int i = 0; i < NUM_POINTS - 1; i++) begin
        sx_r[i] <= sx_r[i+1];
        sy_r[i] <= sy_r[i+1];
      end
    end
  end

  assign out_valid         = busy_r;
  assign out_slot_index    = idx_r;
  assign out_slot_x        = sx_r[0];
  assign out_slot_y        = sy_r[0];
  assign out_touch_mask    = flg_r.mask;
  assign out_new_touch     = flg_r.new_touch;
  assign out_clear_request = flg_r.clear_req;
  assign out_last_slot     = last;

  `TRT_ASSERT_NEXT(a_load_starts, load_i, busy_r && (idx_r == '0))
  `TRT_ASSERT_NOW(a_idx_bound, busy_r, idx_r <= LAST_IDX)

endmodule

/* design/touch_report_tracker.sv */
// Top level of the touch report tracker: input register, state update, result buffer.
//
// Each input request is one scan tick carrying the controller status byte and five
// coordinate pairs; it yields NUM_POINTS results, slot 0 first, the last one flagged
// by out_last_slot. A request is held in an input register, the tracker state is
// updated as the tick moves into the result buffer, and the buffer then presents
// one slot per cycle while out_ready is high. The first result passes through the
// input register and then the result buffer before it reaches the port, and the
// single result port carries the slots one at a time. A new request is taken while
// the previous tick's results are still being delivered. The limits max_x (index 0)
// and max_y (index 1) should only be written while idle.
module touch_report_tracker #(
  parameter int NUM_POINTS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  trt_pkg::coord_t               cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_status_byte,
  input  trt_pkg::coord_t               in_pt0_x,
  input  trt_pkg::coord_t               in_pt0_y,
  input  trt_pkg::coord_t               in_pt1_x,
  input  trt_pkg::coord_t               in_pt1_y,
  input  trt_pkg::coord_t               in_pt2_x,
  input  trt_pkg::coord_t               in_pt2_y,
  input  trt_pkg::coord_t               in_pt3_x,
  input  trt_pkg::coord_t               in_pt3_y,
  input  trt_pkg::coord_t               in_pt4_x,
  input  trt_pkg::coord_t               in_pt4_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [trt_pkg::IDX_W-1:0]     out_slot_index,
  output trt_pkg::coord_t               out_slot_x,
  output trt_pkg::coord_t               out_slot_y,
  output trt_pkg::mask_t                out_touch_mask,
  output logic                          out_new_touch,
  output logic                          out_clear_request,
  output logic                          out_last_slot
);
  import trt_pkg::*;

  logic                    in_vld_r;
  logic [7:0]              status_r;
  coord_t [NPTS_MAX-1:0]   ptx_r, pty_r;
  logic                    fire, can_load;
  coord_t [NUM_POINTS-1:0] trk_x, trk_y;
  trt_flags_t              flags;

  assign fire     = in_vld_r && can_load;
  assign in_ready = !in_vld_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      status_r <= in_status_byte;
      ptx_r    <= {in_pt4_x, in_pt3_x, in_pt2_x, in_pt1_x, in_pt0_x};
      pty_r    <= {in_pt4_y, in_pt3_y, in_pt2_y, in_pt1_y, in_pt0_y};
    end
  end

  trt_core #(.NUM_POINTS(NUM_POINTS)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .fire_i      (fire),
    .status_i    (status_r),
    .pt_x_i      (ptx_r),
    .pt_y_i      (pty_r),
    .trk_x_o     (trk_x),
    .trk_y_o     (trk_y),
    .flags_o     (flags)
  );

  trt_emit #(.NUM_POINTS(NUM_POINTS)) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_i            (fire),
    .x_i               (trk_x),
    .y_i               (trk_y),
    .flags_i           (flags),
    .can_load_o        (can_load),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_slot_index    (out_slot_index),
    .out_slot_x        (out_slot_x),
    .out_slot_y        (out_slot_y),
    .out_touch_mask    (out_touch_mask),
    .out_new_touch     (out_new_touch),
    .out_clear_request (out_clear_request),
    .out_last_slot     (out_last_slot)
  );

endmodule

/* verif/touch_report_tracker_checker.sv */
// Scoreboard for the touch report tracker: follows the ports, predicts every slot and compares.
module touch_report_tracker_checker #(
  parameter int NUM_POINTS = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  trt_pkg::coord_t           cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                in_status_byte,
  input  trt_pkg::coord_t           in_pt0_x,
  input  trt_pkg::coord_t           in_pt0_y,
  input  trt_pkg::coord_t           in_pt1_x,
  input  trt_pkg::coord_t           in_pt1_y,
  input  trt_pkg::coord_t           in_pt2_x,
  input  trt_pkg::coord_t           in_pt2_y,
  input  trt_pkg::coord_t           in_pt3_x,
  input  trt_pkg::coord_t           in_pt3_y,
  input  trt_pkg::coord_t           in_pt4_x,
  input  trt_pkg::coord_t           in_pt4_y,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [trt_pkg::IDX_W-1:0] out_slot_index,
  input  trt_pkg::coord_t           out_slot_x,
  input  trt_pkg::coord_t           out_slot_y,
  input  trt_pkg::mask_t            out_touch_mask,
  input  logic                      out_new_touch,
  input  logic                      out_clear_request,
  input  logic                      out_last_slot,
  output int                        mismatches,
  output int                        pending,
  output int                        n_ticks,
  output int                        n_touches,
  output int                        n_rollbacks,
  output int                        n_wraps
);
  import trt_pkg::*;

  typedef logic [NUM_POINTS-1:0][COORD_W-1:0] pts_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    coord_t           x;
    coord_t           y;
    mask_t            mask;
    logic             fresh;
    logic             clr;
    logic             last;
  } slot_rpt_t;

  // tracker state as the block should hold it
  coord_t     lim_x, lim_y;
  logic [7:0] poll_cnt;
  mask_t      flags;
  coord_t     trk_x [NUM_POINTS];
  coord_t     trk_y [NUM_POINTS];
  slot_rpt_t  due_slots [$];

  function automatic void cmp_field(input string fname, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endfunction

  // one scan tick: update the tracker and queue the slots it should report
  task automatic advance_tracker(input logic [7:0] st_in, input pts_t px, input pts_t py);
    logic [7:0] st;
    logic [3:0] cnt;
    logic       fresh, clr;
    mask_t      saved;
    coord_t     bx, by;
    slot_rpt_t  r;
    st    = '0;
    fresh = 1'b0;
    clr   = 1'b0;
    n_ticks++;
    poll_cnt = poll_cnt + 8'd1;
    if (poll_cnt % 8'd10 == 8'd0 || poll_cnt < POLL_EARLY) begin
      st  = st_in;
      cnt = st[3:0];
      if (st[7] && cnt <= NUM_POINTS) clr = 1'b1;
      if (cnt >= 1 && cnt <= NUM_POINTS) begin
        saved = flags;
        bx    = trk_x[0];
        by    = trk_y[0];
        flags = ((8'd1 << cnt) - 8'd1) | PRESS_BIT | CAUGHT_BIT;
        // old slot 0 is kept in the top slot unless a point lands there
        trk_x[NUM_POINTS-1] = bx;
        trk_y[NUM_POINTS-1] = by;
        for (int i = 0; i < NUM_POINTS; i++) begin
          if (flags[i]) begin
            trk_x[i] = px[i];
            trk_y[i] = py[i];
          end
        end
        fresh = 1'b1;
        if (trk_x[0] > lim_x || trk_y[0] > lim_y) begin
          if (cnt > 1) begin
            trk_x[0] = trk_x[1];
            trk_y[0] = trk_y[1];
            poll_cnt = '0;
            n_touches++;
          end else begin
            // lone point off the panel: undo and treat as a release
            trk_x[0] = bx;
            trk_y[0] = by;
            st       = NOTOUCH_VAL;
            flags    = saved;
            n_rollbacks++;
          end
        end else begin
          poll_cnt = '0;
          n_touches++;
        end
      end
    end
    // no-touch report: release first, clear on the next one
    if ((st & NOTOUCH_SEL) == NOTOUCH_VAL) begin
      if ((flags & PRESS_BIT) != '0) begin
        flags = flags & KEEP_NOPRS;
      end else begin
        trk_x[0] = CLEARED;
        trk_y[0] = CLEARED;
        flags    = flags & KEEP_HIGH;
      end
    end
    if (poll_cnt > POLL_LIMIT) begin
      poll_cnt = POLL_RELOAD;
      n_wraps++;
    end
    for (int i = 0; i < NUM_POINTS; i++) begin
      r.idx   = IDX_W'(i);
      r.x     = trk_x[i];
      r.y     = trk_y[i];
      r.mask  = flags;
      r.fresh = fresh;
      r.clr   = clr;
      r.last  = (i == NUM_POINTS - 1);
      due_slots.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    slot_rpt_t r;
    if (!rst_n) begin
      lim_x    = MAX_X_RST;
      lim_y    = MAX_Y_RST;
      poll_cnt = '0;
      flags    = '0;
      for (int i = 0; i < NUM_POINTS; i++) begin
        trk_x[i] = '0;
        trk_y[i] = '0;
      end
      due_slots.delete();
      mismatches  = 0;
      pending     = 0;
      n_ticks     = 0;
      n_touches   = 0;
      n_rollbacks = 0;
      n_wraps     = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_X) lim_x = cfg_wdata;
        else lim_y = cfg_wdata;
      end
      // compare each delivered slot with the oldest prediction
      if (out_valid && out_ready) begin
        if (due_slots.size() == 0) begin
          $error("slot %0d delivered with no prediction waiting", out_slot_index);
          mismatches++;
        end else begin
          r = due_slots.pop_front();
          cmp_field("slot_index", 32'(r.idx), 32'(out_slot_index));
          cmp_field("slot_x", 32'(r.x), 32'(out_slot_x));
          cmp_field("slot_y", 32'(r.y), 32'(out_slot_y));
          cmp_field("touch_mask", 32'(r.mask), 32'(out_touch_mask));
          cmp_field("new_touch", 32'(r.fresh), 32'(out_new_touch));
          cmp_field("clear_request", 32'(r.clr), 32'(out_clear_request));
          cmp_field("last_slot", 32'(r.last), 32'(out_last_slot));
        end
      end
      if (in_valid && in_ready) begin
        advance_tracker(in_status_byte,
                        {in_pt4_x, in_pt3_x, in_pt2_x, in_pt1_x, in_pt0_x},
                        {in_pt4_y, in_pt3_y, in_pt2_y, in_pt1_y, in_pt0_y});
      end
      pending = due_slots.size();
    end
  end

endmodule

/* verif/touch_report_tracker_tb.sv */
// Testbench top for the touch report tracker: clock, reset, stimulus, idling and verdict.
module touch_report_tracker_tb;
  import trt_pkg::*;

  localparam int NUM_POINTS  = 5;
  localparam int LONG_HOLD   = 200;
  localparam int CYCLE_LIMIT = 300000;

  typedef logic [NUM_POINTS-1:0][COORD_W-1:0] pts_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  coord_t           cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_status_byte;
  coord_t           in_pt0_x, in_pt0_y, in_pt1_x, in_pt1_y, in_pt2_x, in_pt2_y;
  coord_t           in_pt3_x, in_pt3_y, in_pt4_x, in_pt4_y;
  logic             out_valid;
  logic             out_ready;
  logic [IDX_W-1:0] out_slot_index;
  coord_t           out_slot_x, out_slot_y;
  mask_t            out_touch_mask;
  logic             out_new_touch, out_clear_request, out_last_slot;

  int mismatches, pending, n_ticks, n_touches, n_rollbacks, n_wraps;
  int cycle_cnt = 0;

  bit     src_idle_en, sink_idle_en, hold_req;
  coord_t lim_x, lim_y;

  always #6 clk = ~clk;

  touch_report_tracker #(.NUM_POINTS(NUM_POINTS)) dut (.*);

  touch_report_tracker_checker #(.NUM_POINTS(NUM_POINTS)) chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("touch_report_tracker: mismatch");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink
    int n;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 15);
        repeat (n) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // offer one scan tick and hold it until taken
  task automatic send_tick(input logic [7:0] st, input pts_t xs, input pts_t ys);
    int gap;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_status_byte = st;
    in_pt0_x = xs[0];  in_pt0_y = ys[0];
    in_pt1_x = xs[1];  in_pt1_y = ys[1];
    in_pt2_x = xs[2];  in_pt2_y = ys[2];
    in_pt3_x = xs[3];  in_pt3_y = ys[3];
    in_pt4_x = xs[4];  in_pt4_y = ys[4];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic dir_tick(input logic [7:0] st, input coord_t x0, input coord_t y0,
                          input coord_t fill);
    pts_t xs, ys;
    xs    = {NUM_POINTS{fill}};
    ys    = {NUM_POINTS{~fill}};
    xs[0] = x0;
    ys[0] = y0;
    send_tick(st, xs, ys);
  endtask

  // random tick; quiet ones never carry a usable touch count
  task automatic rand_tick(input bit quiet);
    logic [7:0] st;
    pts_t       xs, ys;
    int         r;
    r        = $urandom_range(0, 99);
    st[7]    = 1'($urandom_range(0, 1));
    st[6:4]  = 3'($urandom_range(0, 7));
    if (quiet) st[3:0] = (r < 40) ? 4'd0 : 4'($urandom_range(6, 15));
    else if (r < 15) st[3:0] = 4'd0;
    else if (r < 85) st[3:0] = 4'($urandom_range(1, NUM_POINTS));
    else st[3:0] = 4'($urandom_range(6, 15));
    for (int i = 0; i < NUM_POINTS; i++) begin
      xs[i] = coord_t'($urandom);
      ys[i] = coord_t'($urandom);
    end
    // mostly keep point 0 on the panel
    if ($urandom_range(0, 3) != 0) begin
      xs[0] = coord_t'($urandom_range(0, lim_x));
      ys[0] = coord_t'($urandom_range(0, lim_y));
    end
    send_tick(st, xs, ys);
  endtask

  // stop offering and let every predicted slot come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input cfg_reg_t idx, input coord_t val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_MAX_X) lim_x = val;
    else lim_y = val;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_MAX_X;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_status_byte = '0;
    in_pt0_x = '0;  in_pt0_y = '0;  in_pt1_x = '0;  in_pt1_y = '0;
    in_pt2_x = '0;  in_pt2_y = '0;  in_pt3_x = '0;  in_pt3_y = '0;
    in_pt4_x = '0;  in_pt4_y = '0;
    lim_x        = MAX_X_RST;
    lim_y        = MAX_Y_RST;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    hold_req     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: release/clear, limits, replacement, rollback, odd status bytes
    dir_tick(8'h80, 16'd0, 16'd0, 16'h0000);
    dir_tick(8'h81, 16'd800, 16'd480, 16'hFFFF);
    dir_tick(8'h80, 16'd3, 16'd4, 16'h0001);
    dir_tick(8'h80, 16'd3, 16'd4, 16'h0002);
    dir_tick(8'h85, 16'd0, 16'd0, 16'hFFFF);
    dir_tick(8'h85, 16'hFFFF, 16'hFFFF, 16'h0000);
    dir_tick(8'h02, 16'd801, 16'd0, 16'h1234);
    dir_tick(8'h03, 16'd0, 16'd481, 16'hA5A5);
    dir_tick(8'h01, 16'hFFFF, 16'hFFFF, 16'h0000);
    dir_tick(8'h01, 16'd801, 16'd0, 16'h0F0F);
    dir_tick(8'h86, 16'd5, 16'd5, 16'h0005);
    dir_tick(8'h8F, 16'd6, 16'd6, 16'h8000);
    dir_tick(8'h0F, 16'd7, 16'd7, 16'h00FF);
    dir_tick(8'h00, 16'd8, 16'd8, 16'hFF00);
    dir_tick(8'h04, 16'd100, 16'd200, 16'h5A5A);
    dir_tick(8'hF5, 16'd1, 16'd1, 16'h7FFF);
    dir_tick(8'h70, 16'd9, 16'd9, 16'h3C3C);
    dir_tick(8'hF0, 16'd9, 16'd9, 16'hC3C3);
    dir_tick(8'h80, 16'd9, 16'd9, 16'h6666);
    drain();

    repeat (60) rand_tick(1'b0);
    drain();

    // only a point 0 at the origin counts as in range
    write_limit(REG_MAX_X, 16'h0000);
    write_limit(REG_MAX_Y, 16'h0000);
    repeat (20) rand_tick(1'b0);
    drain();

    write_limit(REG_MAX_X, 16'hFFFF);
    write_limit(REG_MAX_Y, 16'hFFFF);
    repeat (20) rand_tick(1'b0);
    drain();

    // output held off for a long stretch while requests keep coming
    write_limit(REG_MAX_X, coord_t'($urandom_range(1, 4000)));
    write_limit(REG_MAX_Y, coord_t'($urandom_range(1, 4000)));
    hold_req = 1'b1;
    repeat (30) rand_tick(1'b0);
    drain();

    // long quiet run so the poll counter passes its wrap point
    repeat (245) rand_tick(1'b1);
    drain();

    // closing part at full rate
    write_limit(REG_MAX_X, coord_t'($urandom_range(1, 4000)));
    write_limit(REG_MAX_Y, coord_t'($urandom_range(1, 4000)));
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (20) rand_tick(1'b0);
    drain();
    repeat (10) @(posedge clk);

    $display("Ran %0d scan ticks: %0d touch reports taken, %0d rolled back, %0d poll wraps.",
             n_ticks, n_touches, n_rollbacks, n_wraps);
    $display("Limits tried at reset, zero, full scale and random; one long output hold-off.");
    if (mismatches == 0) begin
      $display("touch_report_tracker: match");
    end else begin
      $display("touch_report_tracker: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/trt_pkg.sv
design/trt_core.sv
design/trt_emit.sv
design/touch_report_tracker.sv
verif/touch_report_tracker_checker.sv
verif/touch_report_tracker_tb.sv
